>>> rtl/core/mpjs_pkg.sv
// Shared types and constants for the multi-policy job scheduler.
package mpjs_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  localparam logic [1:0] REQ_NEW = 2'd0;
  localparam logic [1:0] REQ_EXPIRE = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_PRI = 3'd1;
  localparam logic [2:0] POL_PPRI = 3'd2;
  localparam logic [2:0] POL_PSRTF = 3'd3;
  localparam logic [2:0] POL_RR = 3'd4;
  localparam logic [2:0] POL_SJF = 3'd5;

  localparam logic signed [16:0] NOT_RUN = -17'sd1;
  localparam logic signed [16:0] REMAIN_MIN = -17'sd65536;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] job_id;
    logic [15:0] event_time;
    logic [7:0] job_priority;
    logic [15:0] run_time;
    logic evicted_present;
  } req_t;

  typedef struct packed {
    logic selected_valid;
    logic [7:0] selected_id;
    logic table_full;
    logic signed [31:0] waiting_sum;
    logic signed [31:0] turnaround_sum;
    logic signed [31:0] response_sum;
    logic [15:0] jobs_finished;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic apply;
    logic head_clear;
    logic head_step;
    logic [SLOT_W-1:0] idx;
    logic emit;
  } dp_cmd_t;

endpackage

>>> rtl/core/multi_policy_job_scheduler.sv
// Top level of the multi-policy job scheduler.
// A start is ignored while busy is high; busy stays high until the result is emitted.
// Each request runs two slot-at-a-time scans of the table: id/free slot, then head.
// Reset empties the table, clears the sums, counts and policy (fcfs).
// The receiver cannot stall: each result shows for one cycle with done.
module multi_policy_job_scheduler import mpjs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp,
  input  logic policy_we,
  input  logic [2:0] policy_wdata
);

  dp_cmd_t cmd;

  mpjs_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd));

  mpjs_dp u_dp (
    .clk(clk), .rst(rst), .policy_we(policy_we), .policy_wdata(policy_wdata),
    .req(req), .cmd(cmd), .done(done), .rsp(rsp)
  );

endmodule

>>> rtl/core/mpjs_ctrl.sv
// Controller sequencing the slot scan, the update and the head search.
module mpjs_ctrl import mpjs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_HEAD, S_EMIT} state_t;

  state_t state;
  logic [SLOT_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (start) state <= S_SCAN;
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_W'(MAX_JOBS - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          idx <= '0;
          state <= S_HEAD;
        end
        S_HEAD: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_W'(MAX_JOBS - 1)) state <= S_EMIT;
        end
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.load = (state == S_IDLE) && start;
    cmd.scan_clear = cmd.load;
    cmd.scan_step = (state == S_SCAN);
    cmd.apply = (state == S_APPLY);
    cmd.head_clear = (state == S_APPLY);
    cmd.head_step = (state == S_HEAD);
    cmd.emit = (state == S_EMIT);
  end

endmodule

>>> rtl/core/mpjs_dp.sv
// Datapath: job table, slot scan, update, head search and running sums.
module mpjs_dp import mpjs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic policy_we,
  input  logic [2:0] policy_wdata,
  input  req_t req,
  input  dp_cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  logic [2:0] policy;
  req_t r;
  logic [MAX_JOBS-1:0] valid;
  logic [7:0] e_id [MAX_JOBS];
  logic [15:0] e_arr [MAX_JOBS];
  logic [7:0] e_pri [MAX_JOBS];
  logic signed [16:0] e_rem [MAX_JOBS];
  logic [15:0] e_tot [MAX_JOBS];
  logic signed [16:0] e_last [MAX_JOBS];
  logic signed [16:0] e_start [MAX_JOBS];
  logic [15:0] e_ord [MAX_JOBS];
  logic [15:0] order_counter;
  logic [31:0] sum_wait, sum_turn, sum_resp;
  logic [15:0] done_count;
  logic free_found, id_found;
  logic [SLOT_W-1:0] free_slot, id_slot;
  logic head_found;
  logic [SLOT_W-1:0] head;
  logic sel_evicted, full;
  logic [7:0] sel_id;

  function automatic logic signed [17:0] pkey(input logic [2:0] p, input logic [7:0] pr,
                                              input logic signed [16:0] rem,
                                              input logic signed [16:0] last,
                                              input logic [15:0] arr);
    case (p)
      POL_PRI, POL_PPRI: pkey = {10'd0, pr};
      POL_PSRTF, POL_SJF: pkey = {rem[16], rem};
      POL_RR: pkey = {last[16], last};
      default: pkey = {2'd0, arr};
    endcase
  endfunction

  logic [SLOT_W-1:0] c;
  logic signed [17:0] kc, kh;
  logic ahead;

  always_comb begin
    c = cmd.idx;
    kc = pkey(policy, e_pri[c], e_rem[c], e_last[c], e_arr[c]);
    kh = pkey(policy, e_pri[head], e_rem[head], e_last[head], e_arr[head]);
    if (kc != kh) ahead = kc < kh;
    else if (e_arr[c] != e_arr[head]) ahead = e_arr[c] < e_arr[head];
    else ahead = e_ord[c] < e_ord[head];
  end

  logic [31:0] d_wait, d_turn, d_resp;
  always_comb begin
    d_turn = {16'd0, r.event_time} - {16'd0, e_arr[id_slot]};
    d_wait = d_turn - {16'd0, e_tot[id_slot]};
    d_resp = {{15{e_start[id_slot][16]}}, e_start[id_slot]} - {16'd0, e_arr[id_slot]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FCFS;
      valid <= '0;
      order_counter <= '0;
      sum_wait <= '0;
      sum_turn <= '0;
      sum_resp <= '0;
      done_count <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (policy_we) policy <= policy_wdata;
      if (cmd.load) r <= req;
      if (cmd.scan_clear) begin
        free_found <= 1'b0;
        id_found <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (!valid[c] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= c;
        end
        if (valid[c] && !id_found && e_id[c] == r.job_id) begin
          id_found <= 1'b1;
          id_slot <= c;
        end
      end
      if (cmd.apply) begin
        sel_evicted <= 1'b0;
        full <= 1'b0;
        case (r.req_type)
          REQ_NEW: begin
            if (!free_found) full <= 1'b1;
            else begin
              valid[free_slot] <= 1'b1;
              e_id[free_slot] <= r.job_id;
              e_arr[free_slot] <= r.event_time;
              e_pri[free_slot] <= r.job_priority;
              e_rem[free_slot] <= {1'b0, r.run_time};
              e_tot[free_slot] <= r.run_time;
              e_last[free_slot] <= NOT_RUN;
              e_start[free_slot] <= NOT_RUN;
              e_ord[free_slot] <= order_counter;
              order_counter <= order_counter + 16'd1;
            end
          end
          REQ_EXPIRE: begin
            if (r.evicted_present && id_found) begin
              e_last[id_slot] <= {1'b0, r.event_time};
              if (e_rem[id_slot] != REMAIN_MIN) e_rem[id_slot] <= e_rem[id_slot] - 17'sd1;
              if (e_start[id_slot] == NOT_RUN)
                e_start[id_slot] <= $signed({1'b0, r.event_time}) - 17'sd1;
              if (!(policy == POL_PPRI || policy == POL_PSRTF || policy == POL_RR)) begin
                sel_evicted <= 1'b1;
                sel_id <= e_id[id_slot];
              end
            end
          end
          REQ_FINISH: begin
            if (id_found) begin
              sum_wait <= sum_wait + d_wait;
              sum_turn <= sum_turn + d_turn;
              sum_resp <= sum_resp + d_resp;
              done_count <= done_count + 16'd1;
              valid[id_slot] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.head_clear) head_found <= 1'b0;
      if (cmd.head_step && valid[c] && (!head_found || ahead)) begin
        head_found <= 1'b1;
        head <= c;
      end
    end
  end

  always_comb begin
    rsp.table_full = full;
    rsp.waiting_sum = sum_wait;
    rsp.turnaround_sum = sum_turn;
    rsp.response_sum = sum_resp;
    rsp.jobs_finished = done_count;
    if (sel_evicted) begin
      rsp.selected_valid = 1'b1;
      rsp.selected_id = sel_id;
    end else begin
      rsp.selected_valid = head_found;
      rsp.selected_id = head_found ? e_id[head] : 8'd0;
    end
  end

endmodule

>>> rtl/core/mpjs_checker.sv
// Port-level assertions for the multi-policy job scheduler.
module mpjs_checker import mpjs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during done");
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.selected_valid |-> rsp.selected_id == 8'd0) else $error("stray id");

endmodule

bind multi_policy_job_scheduler mpjs_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
